// File: hdl/assert_macros.svh
// assertion macros shared by the frontier store modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled on clk_i, off while rst_ni is low
`define BFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BFS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/bfs_pkg.sv
// types and constants shared by the frontier store modules
`default_nettype none

package bfs_pkg;

  localparam int DATA_W     = 63;
  localparam int CNT_W      = 9;
  localparam int BKT_CFG_W  = 7;
  localparam int TIER_CFG_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CNT_W-1:0]      COUNT_MAX  = 9'd511;
  localparam logic [BKT_CFG_W-1:0]  BKT_RESET  = 7'd64;
  localparam logic [TIER_CFG_W-1:0] TIER_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUCKETS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIERS   = 2'd1;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_ACC    = 3'd1,
    KIND_RD_POS = 3'd2,
    KIND_RD_DIV = 3'd3,
    KIND_FREE   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_LEVEL = 3'd1,
    ST_FULL  = 3'd2,
    ST_TIER  = 3'd3,
    ST_INDEX = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_EXEC  = 3'd2,
    S_ACC   = 3'd3,
    S_DRAIN = 3'd4,
    S_FREE  = 3'd5
  } state_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [5:0]        level;
    logic [3:0]        tier;
    logic [7:0]        item_index;
    logic [DATA_W-1:0] position_value;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] data;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic ptr_clear;
    logic ptr_load_free;
    logic ptr_step;
    logic clr_wr;
    logic acc_rd;
    logic free_wr;
  } cmd_t;

  typedef struct packed {
    logic is_acc;
    logic do_free;
    logic last_all;
    logic last_tier;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/bfs_ctrl.sv
// controller state machine of the frontier store
`default_nettype none
`include "assert_macros.svh"

module bfs_ctrl import bfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic cfg_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.last_all) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.is_acc) begin
          state_d = S_ACC;
        end else if (sts_i.do_free) begin
          state_d = S_FREE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ACC: begin
        if (sts_i.last_all) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      S_FREE: begin
        if (sts_i.last_tier) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    busy        = 1'b1;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cfg_ready_o     = 1'b1;
        cmd_o.clr_wr    = 1'b1;
        cmd_o.ptr_step  = 1'b1;
      end
      S_IDLE: begin
        busy          = 1'b0;
        cfg_ready_o   = 1'b1;
        cmd_o.capture = start;
      end
      S_EXEC: begin
        cmd_o.exec          = 1'b1;
        cmd_o.ptr_clear     = sts_i.is_acc;
        cmd_o.ptr_load_free = sts_i.do_free;
      end
      S_ACC: begin
        cmd_o.acc_rd   = 1'b1;
        cmd_o.ptr_step = 1'b1;
      end
      S_DRAIN: begin
        busy = 1'b1;
      end
      S_FREE: begin
        cmd_o.free_wr  = 1'b1;
        cmd_o.ptr_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `BFS_ASSERT_NEXT(a_accept_exec, start && !busy, state_q == S_EXEC, "accepted transfer did not enter execute")
  `BFS_ASSERT_NEXT(a_exec_once, state_q == S_EXEC, state_q != S_EXEC, "execute lasted more than one cycle")

endmodule

`default_nettype wire

// File: hdl/bfs_dpath.sv
// datapath of the frontier store: config, entry, fill and counter memories
`default_nettype none
`include "assert_macros.svh"

module bfs_dpath import bfs_pkg::*; #(
  parameter int NUM_BUCKETS  = 64,
  parameter int NUM_TIERS    = 16,
  parameter int BUCKET_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  req_t                  req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  rsp_valid_o,
  output rsp_t                  rsp_o
);

  localparam int TOT = NUM_BUCKETS * NUM_TIERS;
  localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int TW  = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
  localparam int CAW = (TOT > 1) ? $clog2(TOT) : 1;
  localparam int EIW = $clog2(BUCKET_DEPTH);
  localparam int EAW = $clog2(NUM_BUCKETS * BUCKET_DEPTH);
  localparam int FW  = $clog2(BUCKET_DEPTH + 1);
  localparam int IXW = FW + 8;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

  logic [DATA_W-1:0] ent_mem  [NUM_BUCKETS * BUCKET_DEPTH];
  logic [FW-1:0]     fill_mem [NUM_BUCKETS];
  logic [CNT_W-1:0]  cnt_mem  [TOT];

  logic [BKT_CFG_W-1:0]  buckets_q;
  logic [TIER_CFG_W-1:0] tiers_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buckets_q <= BKT_RESET;
      tiers_q   <= TIER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDX_BUCKETS: buckets_q <= cfg_data_i;
        CFG_IDX_TIERS:   tiers_q   <= cfg_data_i[TIER_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request side address generation
  logic           in_lvl_ok, in_tier_ok;
  logic [BW-1:0]  in_bidx;
  logic [TW-1:0]  in_tidx;
  logic [CAW-1:0] in_cnt_base, in_cnt_addr;
  logic [EAW-1:0] in_ent_base, in_ent_addr;

  always_comb begin
    in_lvl_ok   = (BKT_CFG_W'(req_i.level) < buckets_q) && (int'(req_i.level) < NUM_BUCKETS);
    in_tier_ok  = (TIER_CFG_W'(req_i.tier) < tiers_q) && (int'(req_i.tier) < NUM_TIERS);
    in_bidx     = in_lvl_ok ? BW'(req_i.level) : '0;
    in_tidx     = in_tier_ok ? TW'(req_i.tier) : '0;
    in_cnt_base = CAW'(in_bidx) * CAW'(NUM_TIERS);
    in_cnt_addr = in_cnt_base + CAW'(in_tidx);
    in_ent_base = EAW'(in_bidx) * EAW'(BUCKET_DEPTH);
    in_ent_addr = in_ent_base + EAW'(EIW'(req_i.item_index));
  end

  req_t           req_q;
  logic           lvl_ok_q, tier_ok_q;
  logic [BW-1:0]  bidx_q;
  logic [CAW-1:0] cnt_base_q, cnt_addr_q;
  logic [EAW-1:0] ent_base_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q      <= req_i;
      lvl_ok_q   <= in_lvl_ok;
      tier_ok_q  <= in_tier_ok;
      bidx_q     <= in_bidx;
      cnt_base_q <= in_cnt_base;
      cnt_addr_q <= in_cnt_addr;
      ent_base_q <= in_ent_base;
    end
  end

  // sweep pointers for clearing, free and accumulate
  logic [CAW-1:0] lin_q;
  logic [BW-1:0]  b_q;
  logic [TW-1:0]  t_q;
  logic           t_last, b_last, lin_last;

  assign t_last   = (t_q == TW'(NUM_TIERS - 1));
  assign b_last   = (b_q == BW'(NUM_BUCKETS - 1));
  assign lin_last = (lin_q == CAW'(TOT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= '0;
      b_q   <= '0;
      t_q   <= '0;
    end else if (cmd_i.ptr_clear) begin
      lin_q <= '0;
      b_q   <= '0;
      t_q   <= '0;
    end else if (cmd_i.ptr_load_free) begin
      lin_q <= cnt_base_q;
      t_q   <= '0;
    end else if (cmd_i.ptr_step) begin
      lin_q <= lin_last ? '0 : lin_q + CAW'(1);
      t_q   <= t_last ? '0 : t_q + TW'(1);
      if (t_last) begin
        b_q <= b_last ? '0 : b_q + BW'(1);
      end
    end
  end

  // accumulate pipeline stage
  logic             s1_valid_q, s1_first_q, s1_use_q;
  logic [CAW-1:0]   s1_addr_q;
  logic [CNT_W-1:0] run_q;
  logic [CNT_W-1:0] acc_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.acc_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= lin_q;
    s1_first_q <= (t_q == '0);
    s1_use_q   <= (t_q != '0) && (int'(t_q) < int'(tiers_q)) && (int'(b_q) < int'(buckets_q));
  end

  // memory read ports
  logic [DATA_W-1:0] ent_rd_q;
  logic [FW-1:0]     fill_rd_q;
  logic [CNT_W-1:0]  cnt_rd_q;
  logic [CAW-1:0]    cnt_raddr;

  assign cnt_raddr = cmd_i.acc_rd ? lin_q : in_cnt_addr;
  assign acc_sum   = sat_add(cnt_rd_q, run_q);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      run_q <= s1_first_q ? cnt_rd_q : acc_sum;
    end
  end

  // execute decode
  logic full, idx_bad, add_ok, free_ok;
  rsp_t rsp_d;

  assign full    = (fill_rd_q == FW'(BUCKET_DEPTH));
  assign idx_bad = (IXW'(req_q.item_index) >= IXW'(fill_rd_q));

  always_comb begin
    add_ok  = 1'b0;
    free_ok = 1'b0;
    rsp_d   = '0;
    unique case (req_q.kind)
      KIND_ADD: begin
        if (!lvl_ok_q) begin
          rsp_d.status = ST_LEVEL;
        end else if (!tier_ok_q) begin
          rsp_d.status = ST_TIER;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          add_ok = 1'b1;
        end
      end
      KIND_ACC: begin
        rsp_d.status = ST_OK;
      end
      KIND_RD_POS: begin
        if (!lvl_ok_q) begin
          rsp_d.status = ST_LEVEL;
        end else if (idx_bad) begin
          rsp_d.status = ST_INDEX;
        end else begin
          rsp_d.data = ent_rd_q;
        end
      end
      KIND_RD_DIV: begin
        if (!lvl_ok_q) begin
          rsp_d.status = ST_LEVEL;
        end else if (!tier_ok_q) begin
          rsp_d.status = ST_TIER;
        end else begin
          rsp_d.data = DATA_W'(cnt_rd_q);
        end
      end
      KIND_FREE: begin
        if (!lvl_ok_q) begin
          rsp_d.status = ST_LEVEL;
        end else begin
          free_ok = 1'b1;
        end
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
  end

  // memory write ports
  logic             cnt_we, fill_we, ent_we;
  logic [CAW-1:0]   cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [BW-1:0]    fill_waddr;
  logic [FW-1:0]    fill_wdata;
  logic [EAW-1:0]   ent_waddr;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = lin_q;
    cnt_wdata = '0;
    if (cmd_i.clr_wr || cmd_i.free_wr) begin
      cnt_we = 1'b1;
    end else if (cmd_i.exec && add_ok) begin
      cnt_we    = 1'b1;
      cnt_waddr = cnt_addr_q;
      cnt_wdata = sat_add(cnt_rd_q, CNT_W'(1));
    end else if (s1_valid_q && s1_use_q) begin
      cnt_we    = 1'b1;
      cnt_waddr = s1_addr_q;
      cnt_wdata = acc_sum;
    end
  end

  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = bidx_q;
    fill_wdata = '0;
    if (cmd_i.clr_wr && (t_q == '0)) begin
      fill_we    = 1'b1;
      fill_waddr = b_q;
    end else if (cmd_i.exec && add_ok) begin
      fill_we    = 1'b1;
      fill_wdata = fill_rd_q + FW'(1);
    end else if (cmd_i.exec && free_ok) begin
      fill_we = 1'b1;
    end
  end

  assign ent_we    = cmd_i.exec && add_ok;
  assign ent_waddr = ent_base_q + EAW'(fill_rd_q[EIW-1:0]);

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= req_q.position_value;
    end
    ent_rd_q <= ent_mem[in_ent_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rd_q <= fill_mem[in_bidx];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // result register
  logic rsp_valid_q;
  rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    sts_o.is_acc    = (req_q.kind == KIND_ACC);
    sts_o.do_free   = free_ok;
    sts_o.last_all  = lin_last;
    sts_o.last_tier = t_last;
  end

  `BFS_ASSERT(a_wr_excl, !(s1_valid_q && (cmd_i.clr_wr || cmd_i.free_wr || cmd_i.exec)), "accumulate write collides with another counter write")
  `BFS_ASSERT_IMP(a_fill_bound, cmd_i.exec, fill_rd_q <= FW'(BUCKET_DEPTH), "bucket fill beyond depth")

endmodule

`default_nettype wire

// File: hdl/bucketed_frontier_store.sv
// top level of the bucketed frontier store
// one transfer accepted on start while busy is low, one result strobe per transfer
// result strobe registered from the execute state, receiver cannot stall
// add, reads, unknown kinds: busy through the execute state, one read and write-back of the memories
// free: clears the bucket's counters over its tiers, accumulate: sweeps all counters, one counter a cycle
// reset: clearing pass over all NUM_BUCKETS * NUM_TIERS counters with busy high, config writes taken
`default_nettype none

module bucketed_frontier_store import bfs_pkg::*; #(
  parameter int NUM_BUCKETS  = 64,
  parameter int NUM_TIERS    = 16,
  parameter int BUCKET_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  rsp_valid_o,
  output rsp_t                  rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  bfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfs_dpath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .NUM_TIERS    (NUM_TIERS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
